@@ hdl/apjb_pkg.sv @@
`default_nettype none

package apjb_pkg;

    // Sample store geometry
    localparam int STORE_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 16) ? CNT_W : 16;

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int AUDIO_W  = 19;
    localparam int RATIO_W  = 5;
    localparam int THRESH_W = 16;
    localparam int BSIZE_W  = 13;
    localparam int PHASE_W  = 4;
    localparam int BPOS_W   = 12;

    // Register limits and reset values
    localparam logic [RATIO_W-1:0]  RATIO_MAX   = 5'd16;
    localparam logic [BSIZE_W-1:0]  BSIZE_MAX   = 13'd4096;
    localparam logic [RATIO_W-1:0]  RATIO_RST   = 5'd6;
    localparam logic [THRESH_W-1:0] START_RST   = 16'd1024;
    localparam logic [THRESH_W-1:0] STOP_RST    = 16'd102;
    localparam logic [BSIZE_W-1:0]  BSIZE_RST   = 13'd64;

    // Output scaling: sample * 33554 >> 13 is sample / 8000 in Q4.15
    localparam logic signed [16:0] SCALE_MUL   = 17'sd33554;
    localparam int                 SCALE_SHIFT = 13;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_PUSH      = 2'd0,
        OP_TICK      = 2'd1,
        OP_NEWSTREAM = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_REPEAT_RATIO    = 2'd0,
        CFG_START_THRESHOLD = 2'd1,
        CFG_STOP_THRESHOLD  = 2'd2,
        CFG_BLOCK_SIZE      = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

@@ hdl/audio_playout_jitter_buffer.sv @@
`default_nettype none

// Playout buffer for 16-bit voice samples. Push beats store a sample in a
// ring of STORE_DEPTH entries; tick beats each return one output beat holding
// the current sample scaled to sample/8000 in signed Q4.15 and the playing
// flag. Each stored sample repeats for repeat_ratio ticks, groups are cut at
// block ends, playback starts once the unread count exceeds start_threshold
// and stops at a block end when it is at or below stop_threshold. One input
// beat is taken every cycle while the output side keeps up. A tick's result
// is presented from registers: the edge that takes it registers the store read,
// and the output register takes the scaled sample when free. Entries never
// written read as zero: the written range of the ring is tracked from the
// write pointer, so no clearing pass follows reset.
module audio_playout_jitter_buffer
    import apjb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] pcm_sample
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [18:0] audio_out, [23:19] zero
    output logic [0:0]       m_tuser,   // [0] playing
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers
    logic [RATIO_W-1:0]  repeat_ratio_reg;
    logic [THRESH_W-1:0] start_threshold_reg;
    logic [THRESH_W-1:0] stop_threshold_reg;
    logic [BSIZE_W-1:0]  block_size_reg;

    // Control state
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wrapped_reg, wrapped_next;
    logic               active_reg, active_next;
    logic               await_reg, await_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BPOS_W-1:0]  bpos_reg, bpos_next;
    logic               silent_reg, silent_next;

    // Pipeline registers
    logic                s1_valid_reg;
    logic                s1_load_reg;
    logic                s1_zero_reg;
    logic                s1_silent_reg;
    logic                s1_playing_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] held_reg;
    logic                out_valid_reg;
    logic [AUDIO_W-1:0]  out_audio_reg;
    logic                out_playing_reg;

    logic [SAMPLE_W-1:0] store [STORE_DEPTH];

    // Handshake and decode
    op_t                 op;
    logic                s2_load;
    logic                s1_adv;
    logic                in_acc;
    logic                push_acc;
    logic                tick_acc;
    logic                newstream_acc;
    logic                load;
    logic                entry_written;

    // Tick arithmetic
    logic [RATIO_W-1:0]  ratio_c;
    logic [BSIZE_W-1:0]  bsize_c;
    logic [RATIO_W-1:0]  phase_inc;
    logic [BSIZE_W-1:0]  bpos_inc;
    logic                start_play;
    logic                active_mid;
    logic                await_mid;
    logic [CNT_W-1:0]    count_mid;

    // Output stage arithmetic
    logic signed [SAMPLE_W-1:0] sample_sel;
    logic signed [32:0]         product;

    assign op            = op_t'(s_tuser);
    assign s2_load       = !out_valid_reg || m_tready;
    assign s1_adv        = !s1_valid_reg || s2_load;
    assign s_tready      = s1_adv;
    assign in_acc        = s_tvalid && s1_adv;
    assign push_acc      = in_acc && (op == OP_PUSH);
    assign tick_acc      = in_acc && (op == OP_TICK);
    assign newstream_acc = in_acc && (op == OP_NEWSTREAM);

    // Entries at or past the write pointer are unwritten until the first wrap
    assign entry_written = wrapped_reg || (rd_ptr_reg < wr_ptr_reg);

    // Clamp the repeat ratio and block size to their legal ranges
    always_comb
    begin
        ratio_c = repeat_ratio_reg;
        if (repeat_ratio_reg == '0)
        begin
            ratio_c = RATIO_W'(1);
        end
        else if (repeat_ratio_reg > RATIO_MAX)
        begin
            ratio_c = RATIO_MAX;
        end
        bsize_c = block_size_reg;
        if (block_size_reg == '0)
        begin
            bsize_c = BSIZE_W'(1);
        end
        else if (block_size_reg > BSIZE_MAX)
        begin
            bsize_c = BSIZE_MAX;
        end
    end

    // Next control state for the accepted beat
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        wrapped_next = wrapped_reg;
        active_next  = active_reg;
        await_next   = await_reg;
        phase_next   = phase_reg;
        bpos_next    = bpos_reg;
        silent_next  = silent_reg;
        load         = 1'b0;
        start_play   = (phase_reg == '0) &&
                       ((await_reg && (CMP_W'(count_reg) > CMP_W'(start_threshold_reg)))
                        || active_reg);
        active_mid   = active_reg;
        await_mid    = await_reg;
        count_mid    = count_reg;
        phase_inc    = RATIO_W'({1'b0, phase_reg}) + RATIO_W'(1);
        bpos_inc     = BSIZE_W'({1'b0, bpos_reg}) + BSIZE_W'(1);

        if (push_acc)
        begin
            if (wr_ptr_reg == ADDR_W'(STORE_DEPTH - 1))
            begin
                wr_ptr_next  = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
            end
            if (count_reg != CNT_W'(STORE_DEPTH))
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (newstream_acc)
        begin
            active_next = 1'b0;
            await_next  = 1'b1;
            phase_next  = '0;
        end
        else if (tick_acc)
        begin
            // Group start: fetch a new sample or go silent
            if (start_play)
            begin
                load       = 1'b1;
                active_mid = 1'b1;
                await_mid  = 1'b0;
                if (rd_ptr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    rd_ptr_next = '0;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                end
                if (count_reg != '0)
                begin
                    count_mid = count_reg - CNT_W'(1);
                end
                silent_next = 1'b0;
            end
            else if (phase_reg == '0)
            begin
                silent_next = 1'b1;
            end
            count_next  = count_mid;
            active_next = active_mid;
            await_next  = await_mid;

            // Advance the repeat group
            if (phase_inc >= ratio_c)
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_inc[PHASE_W-1:0];
            end

            // Block end: restart the group and check for underrun
            if (bpos_inc >= bsize_c)
            begin
                bpos_next  = '0;
                phase_next = '0;
                if (active_mid && (CMP_W'(count_mid) <= CMP_W'(stop_threshold_reg)))
                begin
                    active_next = 1'b0;
                    await_next  = 1'b1;
                end
            end
            else
            begin
                bpos_next = bpos_inc[BPOS_W-1:0];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_ratio_reg    <= RATIO_RST;
            start_threshold_reg <= START_RST;
            stop_threshold_reg  <= STOP_RST;
            block_size_reg      <= BSIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_REPEAT_RATIO:    repeat_ratio_reg    <= cfg_data[RATIO_W-1:0];
                CFG_START_THRESHOLD: start_threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_STOP_THRESHOLD:  stop_threshold_reg  <= cfg_data[THRESH_W-1:0];
                CFG_BLOCK_SIZE:      block_size_reg      <= cfg_data[BSIZE_W-1:0];
                default:             ;
            endcase
        end
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            wrapped_reg <= 1'b0;
            active_reg  <= 1'b0;
            await_reg   <= 1'b1;
            phase_reg   <= '0;
            bpos_reg    <= '0;
            silent_reg  <= 1'b1;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            wrapped_reg <= wrapped_next;
            active_reg  <= active_next;
            await_reg   <= await_next;
            phase_reg   <= phase_next;
            bpos_reg    <= bpos_next;
            silent_reg  <= silent_next;
        end
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            store[wr_ptr_reg] <= s_tdata[SAMPLE_W-1:0];
        end
        if (tick_acc && load)
        begin
            rd_data_reg <= store[rd_ptr_reg];
        end
    end

    // First stage: tick flags that travel with the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= tick_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_load_reg    <= load;
            s1_zero_reg    <= !entry_written;
            s1_silent_reg  <= silent_next;
            s1_playing_reg <= active_next;
        end
    end

    // Second stage: pick the held sample and scale it
    always_comb
    begin
        if (s1_load_reg)
        begin
            sample_sel = s1_zero_reg ? '0 : $signed(rd_data_reg);
        end
        else
        begin
            sample_sel = $signed(held_reg);
        end
        product = sample_sel * SCALE_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            held_reg        <= sample_sel;
            out_audio_reg   <= s1_silent_reg ? '0
                                             : product[SCALE_SHIFT+AUDIO_W-1:SCALE_SHIFT];
            out_playing_reg <= s1_playing_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(24 - AUDIO_W)'(0), out_audio_reg};
    assign m_tuser  = out_playing_reg;

    // Playing and waiting for prefill are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg != await_reg)
        else $error("playing and prefill wait both set or both clear");

    // The unread count never exceeds the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("unread count above store depth");

    // A new stream request leaves the block waiting with a fresh group
    assert property (@(posedge clk) disable iff (!rst_n)
        newstream_acc |=> (!active_reg && await_reg && (phase_reg == '0)))
        else $error("new stream did not restart waiting");

    // A stalled first stage keeps its store read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> $stable(rd_data_reg))
        else $error("store read data changed while stalled");

    // Group phase stays below the clamped ratio unless the ratio just changed
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_acc && $stable(repeat_ratio_reg)) |=>
            (RATIO_W'({1'b0, phase_reg}) < ratio_c))
        else $error("repeat phase out of range");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
import apjb_pkg::*;

// Output scaling: sample * 33554 / 2^13, floored, is sample / 8000 in Q4.15.
localparam int Q15_GAIN  = 33554;
localparam int Q15_SHIFT = 13;
// Hardware ceilings applied to out-of-range register values.
localparam int RATIO_CEIL = 16;
localparam int BLOCK_CEIL = 4096;

// One expected output beat.
typedef struct {
    logic [18:0] audio_out;
    logic        playing;
} playout_beat_t;

// Shadow of the playout buffer plus the queue of output beats it still owes.
class playout_scoreboard;
    logic [15:0]   store [STORE_DEPTH];
    int unsigned   wr_ptr;
    int unsigned   rd_ptr;
    int unsigned   unread;
    bit            active;
    bit            awaiting;
    bit            silent;
    logic [15:0]   held;
    int unsigned   phase;
    int unsigned   bpos;
    int unsigned   ratio_reg;
    int unsigned   start_reg;
    int unsigned   stop_reg;
    int unsigned   bsize_reg;
    playout_beat_t due_beats[$];
    int            errors;
    int            inputs_seen;
    int            outputs_seen;
    int            audible_seen;
    int            overflow_pushes;
    int            empty_reads;

    function new();
        foreach (store[i])
        begin
            store[i] = '0;
        end
        wr_ptr = 0;
        rd_ptr = 0;
        unread = 0;
        active = 1'b0;
        awaiting = 1'b1;
        silent = 1'b1;
        held = '0;
        phase = 0;
        bpos = 0;
        ratio_reg = 6;
        start_reg = 1024;
        stop_reg = 102;
        bsize_reg = 64;
        errors = 0;
        inputs_seen = 0;
        outputs_seen = 0;
        audible_seen = 0;
        overflow_pushes = 0;
        empty_reads = 0;
    endfunction

    // Q4.15 value of a stored sample, rounded toward minus infinity.
    function logic [18:0] q15_of(logic [15:0] raw);
        int prod;
        prod = $signed(raw) * Q15_GAIN;
        return 19'(prod >>> Q15_SHIFT);
    endfunction

    function void write_reg(cfg_index_t idx, logic [15:0] val);
        case (idx)
            CFG_REPEAT_RATIO:    ratio_reg = val[4:0];
            CFG_START_THRESHOLD: start_reg = val;
            CFG_STOP_THRESHOLD:  stop_reg = val;
            CFG_BLOCK_SIZE:      bsize_reg = val[12:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow state by one accepted input beat.
    function void log_input_beat(logic [1:0] op, logic [15:0] pcm);
        int unsigned   lim_ratio;
        int unsigned   lim_block;
        playout_beat_t beat;
        inputs_seen++;
        case (op)
            OP_PUSH:
            begin
                store[wr_ptr] = pcm;
                wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
                if (unread < STORE_DEPTH)
                    unread++;
                else
                    overflow_pushes++;
            end
            OP_NEWSTREAM:
            begin
                active = 1'b0;
                awaiting = 1'b1;
                phase = 0;
            end
            OP_TICK:
            begin
                lim_ratio = (ratio_reg == 0) ? 1 :
                            (ratio_reg > RATIO_CEIL) ? RATIO_CEIL : ratio_reg;
                lim_block = (bsize_reg == 0) ? 1 :
                            (bsize_reg > BLOCK_CEIL) ? BLOCK_CEIL : bsize_reg;
                // A new group fetches a sample if playing or if prefill is met.
                if (phase == 0)
                begin
                    if ((awaiting && unread > start_reg) || active)
                    begin
                        if (awaiting)
                        begin
                            awaiting = 1'b0;
                            active = 1'b1;
                        end
                        held = store[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
                        if (unread > 0)
                            unread--;
                        else
                            empty_reads++;
                        silent = 1'b0;
                    end
                    else
                    begin
                        silent = 1'b1;
                    end
                end
                beat.audio_out = silent ? '0 : q15_of(held);
                phase++;
                if (phase >= lim_ratio)
                    phase = 0;
                // Block end: restart the group and check for underrun.
                bpos++;
                if (bpos >= lim_block)
                begin
                    bpos = 0;
                    phase = 0;
                    if (active && unread <= stop_reg)
                    begin
                        active = 1'b0;
                        awaiting = 1'b1;
                    end
                end
                beat.playing = active;
                due_beats.push_back(beat);
            end
            default: ;
        endcase
    endfunction

    // Compare one output beat with the oldest expected beat.
    function void check_output_beat(logic [18:0] audio, logic playing);
        playout_beat_t exp_beat;
        outputs_seen++;
        if (due_beats.size() == 0)
        begin
            $error("output beat with no tick pending: audio_out %0d, playing %0d",
                   $signed(audio), playing);
            errors++;
            return;
        end
        exp_beat = due_beats.pop_front();
        if (exp_beat.audio_out != 0)
            audible_seen++;
        if (audio !== exp_beat.audio_out)
        begin
            $error("audio_out: expected %0d, actual %0d",
                   $signed(exp_beat.audio_out), $signed(audio));
            errors++;
        end
        if (playing !== exp_beat.playing)
        begin
            $error("playing: expected %0d, actual %0d", exp_beat.playing, playing);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 950;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] pcm_sample
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [18:0] audio_out, [23:19] zero
    logic [0:0]  m_tuser;   // [0] playing
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    bit in_gaps;
    bit out_stalls;
    int stall_left = 0;
    int cycle_count = 0;
    int random_sent = 0;
    int settings_used = 0;

    playout_scoreboard sb;

    audio_playout_jitter_buffer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Output side: ready with random stall bursts while stalls are enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (out_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Observe register writes and both streams at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready)
                sb.log_input_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_output_beat(m_tdata[18:0], m_tuser[0]);
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("audio_playout_jitter_buffer: mismatch");
        $finish;
    end

    function automatic logic [15:0] random_pcm();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Offer one input beat, with an optional idle burst first; returns at a falling edge.
    task automatic send_beat(logic [1:0] op, logic [15:0] pcm);
        int gap;
        if (in_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pcm;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and let every pending tick come out, plus pipeline slack.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four registers on consecutive cycles while the block is idle.
    task automatic set_config(int ratio, int start, int stop, int bsize);
        drain();
        settings_used++;
        cfg_we <= 1'b1;
        cfg_index <= CFG_REPEAT_RATIO;
        cfg_data <= 16'(ratio);
        @(negedge clk);
        cfg_index <= CFG_START_THRESHOLD;
        cfg_data <= 16'(start);
        @(negedge clk);
        cfg_index <= CFG_STOP_THRESHOLD;
        cfg_data <= 16'(stop);
        @(negedge clk);
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data <= 16'(bsize);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random setting followed by bursts of pushes and ticks.
    task automatic random_phase(int idx, int n_items);
        int ratio;
        int start;
        int stop;
        int bsize;
        int kind;
        int len;
        int sent;
        case ($urandom_range(0, 9))
            0: ratio = 0;
            1: ratio = $urandom_range(17, 31);
            default: ratio = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 9))
            0: bsize = 0;
            1: bsize = BLOCK_CEIL;
            2: bsize = $urandom_range(4097, 8191);
            default: bsize = $urandom_range(1, 24);
        endcase
        start = ($urandom_range(0, 11) == 0) ? 32768 : $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0: stop = 65535;
            1: stop = $urandom_range(0, 65535);
            default: stop = $urandom_range(0, 8);
        endcase
        // The first phases pin the register extremes.
        if (idx == 0)
        begin
            ratio = 31;
            bsize = BLOCK_CEIL;
        end
        else if (idx == 1)
        begin
            ratio = RATIO_CEIL;
            bsize = 0;
        end
        else if (idx == 2)
        begin
            ratio = 1;
            bsize = 1;
        end
        set_config(ratio, start, stop, bsize);
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                len = $urandom_range(1, 16);
                repeat (len) send_beat(OP_PUSH, random_pcm());
                sent += len;
            end
            else if (kind < 90)
            begin
                len = $urandom_range(1, 24);
                repeat (len) send_beat(OP_TICK, 16'($urandom()));
                sent += len;
            end
            else if (kind < 95)
            begin
                send_beat(OP_NEWSTREAM, 16'($urandom()));
                sent++;
            end
            else
            begin
                send_beat(OP_UNUSED, 16'($urandom()));
            end
        end
        random_sent += sent;
    endtask

    initial
    begin
        int idx;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_gaps = 1'b1;
        out_stalls = 1'b1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: silence while waiting, ignored op, sample extremes.
        send_beat(OP_TICK, 16'h1234);
        send_beat(OP_UNUSED, 16'h5A5A);
        send_beat(OP_PUSH, 16'h8000);
        send_beat(OP_PUSH, 16'h7FFF);
        send_beat(OP_PUSH, 16'h0000);
        send_beat(OP_PUSH, 16'hFFFF);
        send_beat(OP_PUSH, 16'h0001);
        send_beat(OP_NEWSTREAM, 16'h0000);
        send_beat(OP_TICK, 16'h0000);

        // Ratio zero and an oversized block: play out, then keep reading an empty store.
        set_config(0, 0, 0, 8191);
        repeat (8) send_beat(OP_TICK, 16'($urandom()));
        send_beat(OP_NEWSTREAM, 16'h0000);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_TICK, 16'h0000);

        // Random settings and traffic; the tail runs with no idling.
        idx = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            in_gaps = (idx != 3) && (random_sent < RANDOM_ITEMS * 3 / 4);
            out_stalls = (idx != 4) && (random_sent < RANDOM_ITEMS * 3 / 4);
            random_phase(idx, $urandom_range(90, 140));
            idx++;
        end
        drain();

        $display("Ran %0d input beats under %0d register settings; %0d output beats checked, %0d audible.",
                 sb.inputs_seen, settings_used, sb.outputs_seen, sb.audible_seen);
        $display("Pushes into a full store: %0d; reads from an empty store while playing: %0d.",
                 sb.overflow_pushes, sb.empty_reads);
        if (sb.errors == 0 && sb.due_beats.size() == 0)
            $display("audio_playout_jitter_buffer: match");
        else
            $display("audio_playout_jitter_buffer: mismatch");
        $finish;
    end

endmodule
